FILE: rtl/cppq_pkg.sv
// package: constants, types and opcodes of the cutoff-purged playback queue
`timescale 1ns / 1ps

package cppq_pkg;

    localparam int QDEPTH    = 4;
    localparam int TIME_BITS = 42;
    localparam int OP_W      = 2;
    localparam int CNT_OUT_W = 3;
    localparam int CNT_W     = $clog2(QDEPTH + 1);
    localparam int IDX_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_OUT_W-1:0] cnt_out_t;

    localparam cnt_t CNT_FULL = CNT_W'(QDEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_AUDIO = 2'd0,
        OP_INTR  = 2'd1,
        OP_DRAIN = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic  wr_en;
        idx_t  wr_idx;
        time_t wr_data;
        idx_t  rd_idx;
    } store_ctrl_t;

endpackage

FILE: rtl/cppq_ifs.sv
// interfaces: request and response channels of the playback queue
`timescale 1ns / 1ps

interface cppq_req_if;
    logic                     valid;
    logic                     ready;
    logic [cppq_pkg::OP_W-1:0] opcode;
    logic                     starts_stream;
    logic                     has_payload;
    cppq_pkg::time_t          packet_time;
    cppq_pkg::time_t          interrupt_cutoff;

    modport source (
        output valid, opcode, starts_stream, has_payload, packet_time, interrupt_cutoff,
        input  ready
    );
    modport sink (
        input  valid, opcode, starts_stream, has_payload, packet_time, interrupt_cutoff,
        output ready
    );
endinterface

interface cppq_rsp_if;
    logic               valid;
    logic               ready;
    logic               admit;
    logic               enqueued;
    logic               popped;
    cppq_pkg::cnt_out_t entry_count;
    cppq_pkg::time_t    head_time;
    cppq_pkg::time_t    cutoff_now;

    modport source (
        output valid, admit, enqueued, popped, entry_count, head_time, cutoff_now,
        input  ready
    );
    modport sink (
        input  valid, admit, enqueued, popped, entry_count, head_time, cutoff_now,
        output ready
    );
endinterface

FILE: rtl/cppq_store.sv
// queue entry storage: one write port, one indexed read port, fixed head read
`timescale 1ns / 1ps

module cppq_store (
    input  logic                  clk,
    input  cppq_pkg::store_ctrl_t ctrl,
    output cppq_pkg::time_t       rd_data,
    output cppq_pkg::time_t       head
);

    cppq_pkg::time_t entry_reg [cppq_pkg::QDEPTH];

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            entry_reg[ctrl.wr_idx] <= ctrl.wr_data;
        end
    end

    assign rd_data = entry_reg[ctrl.rd_idx];
    assign head    = entry_reg[0];

endmodule

FILE: rtl/cutoff_purged_playback_queue_core.sv
// top level: sequencer and shared comparator of the cutoff-purged playback queue
// sequence: accept in IDLE, then EXEC; a drain tick shifts the held entries in SHIFT,
// an interrupt compacts them in SCAN, then FINISH; one entry is examined or moved per cycle
// through the single 42-bit comparator and the single storage write port
// throughput: one item at a time; the next item is taken once the result is registered
// reset: rst_n clears cutoff, stream start, entry count and handshake state
`timescale 1ns / 1ps

module cutoff_purged_playback_queue_core (
    input  logic       clk,
    input  logic       rst_n,
    cppq_req_if.sink   req,
    cppq_rsp_if.source rsp
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    state_t                state_reg, state_next;
    cppq_pkg::op_t         op_reg, op_next;
    logic                  starts_reg, starts_next;
    logic                  payload_reg, payload_next;
    cppq_pkg::time_t       ptime_reg, ptime_next;
    cppq_pkg::time_t       icut_reg, icut_next;
    cppq_pkg::time_t       cutoff_reg, cutoff_next;
    cppq_pkg::time_t       css_reg, css_next;
    cppq_pkg::cnt_t        count_reg, count_next;
    cppq_pkg::cnt_t        scan_reg, scan_next;
    cppq_pkg::cnt_t        kept_reg, kept_next;
    logic                  enq_reg, enq_next;
    logic                  pop_reg, pop_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  admit_reg, admit_next;
    logic                  enqd_reg, enqd_next;
    logic                  popd_reg, popd_next;
    cppq_pkg::cnt_out_t    ocount_reg, ocount_next;
    cppq_pkg::time_t       head_reg, head_next;
    cppq_pkg::time_t       ocut_reg, ocut_next;

    cppq_pkg::store_ctrl_t ctrl;
    cppq_pkg::time_t       rd_data;
    cppq_pkg::time_t       head;
    cppq_pkg::time_t       cmp_a;
    logic                  cmp_gt;
    cppq_pkg::time_t       css_eff;
    cppq_pkg::cnt_t        scan_inc;

    cppq_store u_store (
        .clk     (clk),
        .ctrl    (ctrl),
        .rd_data (rd_data),
        .head    (head)
    );

    // shared compare unit, always against the current cutoff
    assign cmp_gt   = cmp_a > cutoff_reg;
    assign css_eff  = starts_reg ? ptime_reg : css_reg;
    assign scan_inc = scan_reg + cppq_pkg::cnt_t'(1);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        starts_next    = starts_reg;
        payload_next   = payload_reg;
        ptime_next     = ptime_reg;
        icut_next      = icut_reg;
        cutoff_next    = cutoff_reg;
        css_next       = css_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        kept_next      = kept_reg;
        enq_next       = enq_reg;
        pop_next       = pop_reg;
        out_valid_next = out_valid_reg;
        admit_next     = admit_reg;
        enqd_next      = enqd_reg;
        popd_next      = popd_reg;
        ocount_next    = ocount_reg;
        head_next      = head_reg;
        ocut_next      = ocut_reg;
        ctrl           = '0;
        cmp_a          = cutoff_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next      = cppq_pkg::op_t'(req.opcode);
                    starts_next  = req.starts_stream;
                    payload_next = req.has_payload;
                    ptime_next   = req.packet_time;
                    icut_next    = req.interrupt_cutoff;
                    enq_next     = 1'b0;
                    pop_next     = 1'b0;
                    scan_next    = '0;
                    kept_next    = '0;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (op_reg)
                    cppq_pkg::OP_AUDIO:
                    begin
                        css_next = css_eff;
                        cmp_a    = css_eff;
                        if (payload_reg && cmp_gt && (count_reg < cppq_pkg::CNT_FULL))
                        begin
                            ctrl.wr_en   = 1'b1;
                            ctrl.wr_idx  = count_reg[cppq_pkg::IDX_W-1:0];
                            ctrl.wr_data = css_eff;
                            count_next   = count_reg + cppq_pkg::cnt_t'(1);
                            enq_next     = 1'b1;
                        end
                        state_next = ST_FINISH;
                    end
                    cppq_pkg::OP_INTR:
                    begin
                        // unusable interrupt time falls back to the stream start
                        cmp_a = (icut_reg != '0) ? icut_reg : css_reg;
                        if (cmp_gt)
                        begin
                            cutoff_next = cmp_a;
                        end
                        state_next = ST_SCAN;
                    end
                    cppq_pkg::OP_DRAIN:
                    begin
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - cppq_pkg::cnt_t'(1);
                            pop_next   = 1'b1;
                            state_next = ST_SHIFT;
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_SCAN:
            begin
                // compaction: keep entries strictly above the cutoff
                ctrl.rd_idx = scan_reg[cppq_pkg::IDX_W-1:0];
                cmp_a       = rd_data;
                if (scan_reg == count_reg)
                begin
                    count_next = kept_reg;
                    state_next = ST_FINISH;
                end
                else
                begin
                    if (cmp_gt)
                    begin
                        ctrl.wr_en   = 1'b1;
                        ctrl.wr_idx  = kept_reg[cppq_pkg::IDX_W-1:0];
                        ctrl.wr_data = rd_data;
                        kept_next    = kept_reg + cppq_pkg::cnt_t'(1);
                    end
                    scan_next = scan_inc;
                end
            end
            ST_SHIFT:
            begin
                ctrl.rd_idx = scan_inc[cppq_pkg::IDX_W-1:0];
                if (scan_reg == count_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    ctrl.wr_en   = 1'b1;
                    ctrl.wr_idx  = scan_reg[cppq_pkg::IDX_W-1:0];
                    ctrl.wr_data = rd_data;
                    scan_next    = scan_inc;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    admit_next     = count_reg < cppq_pkg::CNT_FULL;
                    enqd_next      = enq_reg;
                    popd_next      = pop_reg;
                    ocount_next    = cppq_pkg::CNT_OUT_W'(count_reg);
                    head_next      = (count_reg != '0) ? head : '0;
                    ocut_next      = cutoff_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cutoff_reg    <= '0;
            css_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cutoff_reg    <= cutoff_next;
            css_reg       <= css_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        starts_reg  <= starts_next;
        payload_reg <= payload_next;
        ptime_reg   <= ptime_next;
        icut_reg    <= icut_next;
        scan_reg    <= scan_next;
        kept_reg    <= kept_next;
        enq_reg     <= enq_next;
        pop_reg     <= pop_next;
        admit_reg   <= admit_next;
        enqd_reg    <= enqd_next;
        popd_reg    <= popd_next;
        ocount_reg  <= ocount_next;
        head_reg    <= head_next;
        ocut_reg    <= ocut_next;
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.admit       = admit_reg;
    assign rsp.enqueued    = enqd_reg;
    assign rsp.popped      = popd_reg;
    assign rsp.entry_count = ocount_reg;
    assign rsp.head_time   = head_reg;
    assign rsp.cutoff_now  = ocut_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cppq_pkg::CNT_FULL)
        else $error("entry count above queue depth");

    a_cutoff_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> cutoff_reg >= $past(cutoff_reg))
        else $error("cutoff decreased");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req.ready)
        else $error("item taken while busy");

    a_enq_pop_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.enqueued) |-> !rsp.popped)
        else $error("result both enqueued and popped");

endmodule
